// File: rtl/core/svs_pkg.sv
// shared types and constants of the sparse vector store alu
// no dependencies; imported by the alu and the top level
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned EIDX_W = 6;
  localparam int unsigned VEC_W  = 2;
  localparam int unsigned LENC_W = 7;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET = 3'd0,
    OP_GET = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_DOT = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  // control from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic acc_clr;
    logic sub;
    logic mul_en;
    logic acc_en;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/svs_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module svs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/svs_alu.sv
// shared element unit: saturating add/subtract, multiplier and
// saturating 64-bit accumulator; depends on svs_pkg
`timescale 1ns / 1ps
`default_nettype none

module svs_alu (
  input  wire logic                      clk_i,
  input  wire svs_pkg::alu_ctrl_t        ctrl_i,
  input  wire logic signed [31:0]        a_i,
  input  wire logic signed [31:0]        b_i,
  output logic signed      [31:0]        sum_o,
  output logic                           sum_sat_o,
  output logic signed      [63:0]        acc_o,
  output logic                           acc_sat_o
);

  import svs_pkg::*;

  logic signed [DATA_W:0]   wide_d;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic        [ACC_W-1:0]  step_sum;

  // 33-bit sum, overflow when the top two bits disagree
  always_comb begin
    if (ctrl_i.sub) begin
      wide_d = {a_i[DATA_W-1], a_i} - {b_i[DATA_W-1], b_i};
    end else begin
      wide_d = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};
    end
    sum_sat_o = wide_d[DATA_W] != wide_d[DATA_W-1];
    if (!sum_sat_o) begin
      sum_o = wide_d[DATA_W-1:0];
    end else if (wide_d[DATA_W]) begin
      sum_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    step_sum  = acc_q + prod_q;
    acc_sat_o = (acc_q[ACC_W-1] == prod_q[ACC_W-1]) &&
                (step_sum[ACC_W-1] != acc_q[ACC_W-1]);
    if (!acc_sat_o) begin
      acc_d = step_sum;
    end else if (acc_q[ACC_W-1]) begin
      acc_d = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_d = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/core/sparse_vector_store_alu_top.sv
// sparse vector store alu top level: sequencer, store and config port
// depends on svs_pkg, svs_ram, svs_alu
`timescale 1ns / 1ps
`default_nettype none

// channel      direction  handshake                 content
// s_axis       in         tvalid/tready             one operation
// m_axis       out        tvalid/tready             one result per operation
// apb          in/out     psel/penable, pready = 1  vector_length at address 0
//
// after reset the store is cleared, one word a cycle, all NUM_VECTORS*MAX_LENGTH
// words (256 at defaults); no operation is taken meanwhile
// set writes and get reads a single element, unused codes touch no element;
// add/subtract and dot run one element a cycle through the store read
// ports and the shared element unit
// a finished result waits in the output register, the next operation is
// taken while it is held; a stalled result only blocks the following one

module sparse_vector_store_alu_top #(
  parameter int unsigned MAX_LENGTH  = 64,
  parameter int unsigned NUM_VECTORS = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[2:0], elem_index[8:3], elem_value[40:9], vec_a[42:41],
  // vec_b[44:43], vec_dest[46:45], zero[47]
  input  wire logic [47:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_value[31:0], dot_value[95:32], status[97:96], zero[103:98]
  output logic      [103:0] m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  import svs_pkg::*;

  localparam int unsigned DEPTH   = NUM_VECTORS * MAX_LENGTH;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned IDX_W   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LEN_W   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned VSEL_W  = $clog2(NUM_VECTORS);
  localparam int unsigned LEN_RST = (MAX_LENGTH > 127) ? 127 : MAX_LENGTH;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_RUN    = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [LENC_W-1:0]     len_cfg_q;
  logic [LEN_W-1:0]      eff_len;
  logic [ADDR_W-1:0]     clr_q;
  logic [LEN_W-1:0]      cnt_q;
  logic [LEN_W-1:0]      issue_cnt;
  logic                  issue;
  logic [IDX_W-1:0]      cnt_idx;
  logic                  in_range;

  logic [OP_W-1:0]       op_q;
  logic [EIDX_W-1:0]     idx_q;
  logic signed [31:0]    val_q;
  logic [VSEL_W-1:0]     va_q, vb_q, vd_q;
  logic [ADDR_W-1:0]     dst_q;
  logic                  p1_q, p2_q;
  logic                  sat_q;
  logic signed [31:0]    read_q;

  logic                  in_xfer;
  logic                  out_load;
  logic                  out_valid_q;
  logic signed [31:0]    out_read_q;
  logic signed [63:0]    out_dot_q;
  logic [STAT_W-1:0]     out_status_q;
  status_e               status_d;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [31:0]           ram_wdata;
  logic [ADDR_W-1:0]     raddr_a, raddr_b;
  logic signed [31:0]    rd_a, rd_b;

  alu_ctrl_t             alu_ctrl;
  logic signed [31:0]    alu_sum;
  logic                  alu_sum_sat;
  logic signed [63:0]    alu_acc;
  logic                  alu_acc_sat;

  // vector select taken modulo the number of vectors
  function automatic logic [VSEL_W-1:0] vsel(input logic [VEC_W-1:0] v);
    logic [4:0] t;
    t = 5'(v);
    if (t >= 5'(NUM_VECTORS)) begin
      t = t - 5'(NUM_VECTORS);
    end
    return VSEL_W'(t);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [VSEL_W-1:0] v,
                                             input logic [IDX_W-1:0]  i);
    return ADDR_W'(v) * ADDR_W'(MAX_LENGTH) + ADDR_W'(i);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(len_cfg_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LENC_W'(LEN_RST);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      len_cfg_q <= pwdata[LENC_W-1:0];
    end
  end

  always_comb begin
    if (len_cfg_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_cfg_q) > MAX_LENGTH) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = LEN_W'(len_cfg_q);
    end
  end

  assign in_range = 32'(idx_q) < 32'(eff_len);
  assign cnt_idx  = cnt_q[IDX_W-1:0];

  // number of element reads the operation issues
  always_comb begin
    case (op_q)
      OP_ADD, OP_SUB, OP_DOT: issue_cnt = eff_len;
      OP_GET:                 issue_cnt = in_range ? LEN_W'(1) : '0;
      default:                issue_cnt = '0;
    endcase
  end

  assign issue         = (state_q == S_RUN) && (cnt_q < issue_cnt);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_d = S_RUN;
      end
      S_RUN: begin
        if (!issue && !p1_q && !p2_q) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      sat_q   <= 1'b0;
      op_q    <= OP_SET;
    end else begin
      state_q <= state_d;
      p1_q    <= issue;
      p2_q    <= p1_q && (op_q == OP_DOT);
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (in_xfer) begin
        op_q  <= s_axis_tdata[2:0];
        cnt_q <= '0;
        sat_q <= 1'b0;
      end else begin
        if (issue) cnt_q <= cnt_q + LEN_W'(1);
        if ((p1_q && alu_sum_sat && (op_q == OP_ADD || op_q == OP_SUB)) ||
            (p2_q && alu_acc_sat)) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  // operation fields and per-element payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q  <= s_axis_tdata[8:3];
      val_q  <= s_axis_tdata[40:9];
      va_q   <= vsel(s_axis_tdata[42:41]);
      vb_q   <= vsel(s_axis_tdata[44:43]);
      vd_q   <= vsel(s_axis_tdata[46:45]);
      read_q <= '0;
    end else if (p1_q && op_q == OP_GET) begin
      read_q <= rd_a;
    end
    if (issue) begin
      dst_q <= slot(vd_q, cnt_idx);
    end
  end

  // store ports
  assign raddr_a = (op_q == OP_GET) ? slot(va_q, IDX_W'(idx_q)) : slot(va_q, cnt_idx);
  assign raddr_b = slot(vb_q, cnt_idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = alu_sum;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_RUN && op_q == OP_SET) begin
      ram_we    = in_range;
      ram_waddr = slot(va_q, IDX_W'(idx_q));
      ram_wdata = val_q;
    end else if (p1_q && (op_q == OP_ADD || op_q == OP_SUB)) begin
      ram_we = 1'b1;
    end
  end

  svs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    alu_ctrl.acc_clr = in_xfer;
    alu_ctrl.sub     = (op_q == OP_SUB);
    alu_ctrl.mul_en  = p1_q && (op_q == OP_DOT);
    alu_ctrl.acc_en  = p2_q;
  end

  svs_alu u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .a_i       (rd_a),
    .b_i       (rd_b),
    .sum_o     (alu_sum),
    .sum_sat_o (alu_sum_sat),
    .acc_o     (alu_acc),
    .acc_sat_o (alu_acc_sat)
  );

  // result register
  always_comb begin
    if ((op_q == OP_SET || op_q == OP_GET) && !in_range) begin
      status_d = STAT_RANGE;
    end else if (sat_q) begin
      status_d = STAT_SAT;
    end else begin
      status_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_read_q   <= read_q;
      out_dot_q    <= (op_q == OP_DOT) ? alu_acc : '0;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_status_q, out_dot_q, out_read_q};

  // checks
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FINISH) |-> !ram_we)
    else $error("store written outside an operation");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result loaded outside finish");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q <= issue_cnt))
    else $error("element counter past the vector length");

  a_pipe_empty_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!p1_q && !p2_q))
    else $error("operation taken while elements in flight");

endmodule

`default_nettype wire
